// ===== rtl/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEPTH      = 64;
   localparam int ELEM_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int QDEPTH     = 2;

   typedef enum logic [3:0] {
      CMD_INIT     = 4'd0,
      CMD_DESTROY  = 4'd1,
      CMD_CLEAR    = 4'd2,
      CMD_GET      = 4'd3,
      CMD_LOCATE   = 4'd4,
      CMD_PRIOR    = 4'd5,
      CMD_NEXT     = 4'd6,
      CMD_INSERT   = 4'd7,
      CMD_DELETE   = 4'd8,
      CMD_TRAVERSE = 4'd9
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOINIT   = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_NONEIGH  = 3'd4,
      ST_ALREADY  = 3'd5,
      ST_FULL     = 3'd6,
      ST_EMPTY    = 3'd7
   } status_type;

   // one classified transaction handed from front to back
   typedef struct packed {
      cmd_type                cmd;
      logic [7:0]             pos;
      logic [ELEM_WIDTH-1:0]  value;
   } job_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_DISPATCH,
      BK_SEARCH,
      BK_NEIGH,
      BK_GETRD,
      BK_SHIFT_UP,
      BK_SHIFT_DN,
      BK_DELRD,
      BK_TRAV,
      BK_EMIT
   } bk_state_type;

endpackage

// ===== rtl/positional_list_engine.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words with positional and value commands.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  command, position, value
//   rsp_     out        rsp_valid/rsp_stall  status, value_out, found_position,
//                                            list_length, is_initialized, last
//
// Locate, prior, next, insert, delete and traverse walk the element memory word
// by word through its single read and write port; insert moves each word with a
// read and then a write, while delete overlaps the read of one word with the write of another.
// Reset is synchronous and clears the list flags; memory contents are not cleared.
// A stalled result holds the back end, which starts no new command until the
// result has left; the front queue keeps taking requests until it fills.
// ----------------------------------------------------------------------------
module positional_list_engine
   import ple_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_command,
   input  logic [7:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_value_out,
   output logic [6:0]         rsp_found_position,
   output logic [6:0]         rsp_list_length,
   output logic               rsp_is_initialized,
   output logic               rsp_last
);

   logic    job_valid, job_take;
   job_type job_data;

   ple_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_command, .req_position,
      .req_value, .job_valid, .job_data, .job_take
   );

   ple_back u_back (
      .clock, .reset, .job_valid, .job_data, .job_take, .rsp_valid, .rsp_stall,
      .rsp_status, .rsp_value_out, .rsp_found_position, .rsp_list_length,
      .rsp_is_initialized, .rsp_last
   );

endmodule

// ===== rtl/ple_front.sv =====
// ----------------------------------------------------------------------------
// ple_front
// Accepts request transactions, drops unknown commands and queues the rest.
// ----------------------------------------------------------------------------
module ple_front
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [3:0]            req_command,
   input  logic [7:0]            req_position,
   input  logic signed [31:0]    req_value,
   output logic                  job_valid,
   output job_type               job_data,
   input  logic                  job_take
);

   localparam int QP_W = $clog2(QDEPTH);

   job_type         q_ff [QDEPTH];
   logic [QP_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QP_W:0]   cnt_ff, cnt_in;
   logic            push, pop;
   job_type         incoming;

   assign req_stall = (cnt_ff == (QP_W+1)'(QDEPTH));
   assign incoming.cmd   = cmd_type'(req_command);
   assign incoming.pos   = req_position;
   assign incoming.value = ELEM_WIDTH'(req_value);

   // drop commands beyond traverse
   assign push = req_valid && !req_stall && (req_command <= 4'(CMD_TRAVERSE));
   assign pop  = job_take && job_valid;
   assign job_valid = (cnt_ff != '0);
   assign job_data  = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? QP_W'(wp_ff + 1'b1) : wp_ff;
      rp_in  = pop  ? QP_W'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (QP_W+1)'(push) - (QP_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) q_ff[wp_ff] <= incoming;
   end

endmodule

// ===== rtl/ple_back.sv =====
// ----------------------------------------------------------------------------
// ple_back
// Executes list commands on the element memory, one command at a time.
// ----------------------------------------------------------------------------
module ple_back
   import ple_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  job_valid,
   input  job_type               job_data,
   output logic                  job_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic signed [31:0]    rsp_value_out,
   output logic [6:0]            rsp_found_position,
   output logic [6:0]            rsp_list_length,
   output logic                  rsp_is_initialized,
   output logic                  rsp_last
);

   logic [ELEM_WIDTH-1:0] mem [DEPTH];
   logic [ELEM_WIDTH-1:0] rd_ff;

   bk_state_type state_ff, state_in;
   job_type      job_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             exists_ff, exists_in;
   logic [CNT_W-1:0] i_ff, i_in;
   logic             pend_ff, pend_in;   // read data valid in rd_ff

   // output register
   logic             ov_ff, ov_in;
   status_type       ost_ff, ost_in;
   logic [ELEM_WIDTH-1:0] oval_ff, oval_in;
   logic [6:0]       ofp_ff, ofp_in;
   logic             olast_ff, olast_in;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [ELEM_WIDTH-1:0] wr_data;
   logic [CNT_W-1:0] posc;
   logic             out_free;

   // clamp large positions to a value that is out of range for every command
   assign posc     = (job_ff.pos > 8'(DEPTH + 1)) ? CNT_W'(DEPTH + 2) : CNT_W'(job_ff.pos);
   assign out_free = !ov_ff || !rsp_stall;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:     if (job_valid && !ov_ff) state_in = BK_DISPATCH;
         BK_DISPATCH: begin
            priority if (job_ff.cmd == CMD_INIT || !exists_ff) state_in = BK_EMIT;
            else begin
               unique case (job_ff.cmd)
                  CMD_GET:
                     state_in = (count_ff != '0 && posc >= 1 && posc <= count_ff)
                                ? BK_GETRD : BK_EMIT;
                  CMD_LOCATE, CMD_PRIOR, CMD_NEXT:
                     state_in = (count_ff != '0) ? BK_SEARCH : BK_EMIT;
                  CMD_INSERT:
                     state_in = (posc >= 1 && posc <= count_ff + 1'b1 &&
                                 count_ff < CNT_W'(DEPTH)) ? BK_SHIFT_UP : BK_EMIT;
                  CMD_DELETE:
                     state_in = (count_ff != '0 && posc >= 1 && posc <= count_ff)
                                ? BK_DELRD : BK_EMIT;
                  CMD_TRAVERSE:
                     state_in = (count_ff != '0) ? BK_TRAV : BK_EMIT;
                  default: state_in = BK_EMIT;
               endcase
            end
         end
         BK_SEARCH: begin
            if (pend_ff && rd_ff == job_ff.value) begin
               if (job_ff.cmd == CMD_LOCATE) state_in = BK_EMIT;
               else if (job_ff.cmd == CMD_PRIOR)
                  state_in = (i_ff == CNT_W'(1)) ? BK_EMIT : BK_NEIGH;
               else state_in = (i_ff >= count_ff) ? BK_EMIT : BK_NEIGH;
            end else if (pend_ff && i_ff >= count_ff) state_in = BK_EMIT;
         end
         BK_NEIGH:    if (pend_ff) state_in = BK_EMIT;
         BK_GETRD:    if (pend_ff) state_in = BK_EMIT;
         BK_SHIFT_UP: if (i_ff < posc || (i_ff == posc && !pend_ff && i_ff != count_ff
                                           && 1'b0)) state_in = BK_EMIT;
                      else if (i_ff == posc - 1'b1) state_in = BK_EMIT;
         BK_DELRD:    if (pend_ff && i_ff >= count_ff) state_in = BK_EMIT;
         BK_TRAV:     if (out_free && pend_ff && i_ff == count_ff) state_in = BK_IDLE;
         BK_EMIT:     if (out_free) state_in = BK_IDLE;
         default:     state_in = BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in  = count_ff;
      exists_in = exists_ff;
      i_in      = i_ff;
      pend_in   = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = job_ff.value;
      job_take  = 1'b0;
      ov_in     = ov_ff && rsp_stall;
      ost_in    = ost_ff;
      oval_in   = oval_ff;
      ofp_in    = ofp_ff;
      olast_in  = olast_ff;
      unique case (state_ff)
         // wait until the last result has left before starting the next job
         BK_IDLE: job_take = job_valid && !ov_ff;
         BK_DISPATCH: begin
            ost_in  = ST_OK;
            oval_in = '0;
            ofp_in  = '0;
            olast_in = 1'b1;
            priority if (job_ff.cmd == CMD_INIT) begin
               if (exists_ff) ost_in = ST_ALREADY;
               else begin
                  exists_in = 1'b1;
                  count_in  = '0;
               end
            end else if (!exists_ff) ost_in = ST_NOINIT;
            else begin
               unique case (job_ff.cmd)
                  CMD_DESTROY: begin
                     exists_in = 1'b0;
                     count_in  = '0;
                  end
                  CMD_CLEAR: count_in = '0;
                  CMD_GET, CMD_DELETE: begin
                     if (count_ff == '0) ost_in = ST_EMPTY;
                     else if (posc < 1 || posc > count_ff) ost_in = ST_BADPOS;
                     i_in = posc - 1'b1;
                  end
                  CMD_LOCATE, CMD_PRIOR, CMD_NEXT: begin
                     ost_in = ST_NOTFOUND;
                     i_in   = '0;
                  end
                  CMD_INSERT: begin
                     if (posc < 1 || posc > count_ff + 1'b1) ost_in = ST_BADPOS;
                     else if (count_ff >= CNT_W'(DEPTH)) ost_in = ST_FULL;
                     i_in = count_ff;
                  end
                  CMD_TRAVERSE: begin
                     if (count_ff == '0) ost_in = ST_EMPTY;
                     i_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         BK_SEARCH: begin
            // walk forward, compare the word read last cycle
            if (pend_ff && rd_ff == job_ff.value) begin
               if (job_ff.cmd == CMD_LOCATE) begin
                  ost_in = ST_OK;
                  ofp_in = 7'(i_ff);
               end else if (job_ff.cmd == CMD_PRIOR) begin
                  if (i_ff == CNT_W'(1)) ost_in = ST_NONEIGH;
                  else begin
                     rd_en   = 1'b1;
                     rd_addr = IDX_W'(i_ff - 2'd2);
                     pend_in = 1'b1;
                  end
               end else begin
                  if (i_ff >= count_ff) ost_in = ST_NONEIGH;
                  else begin
                     rd_en   = 1'b1;
                     rd_addr = IDX_W'(i_ff);
                     pend_in = 1'b1;
                  end
               end
            end else if (!(pend_ff && i_ff >= count_ff)) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(i_ff);
               pend_in = 1'b1;
               i_in    = i_ff + 1'b1;
            end
         end
         BK_NEIGH, BK_GETRD: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(i_ff);
               pend_in = 1'b1;
            end else begin
               ost_in  = ST_OK;
               oval_in = rd_ff;
            end
            if (state_ff == BK_NEIGH) i_in = i_ff;
         end
         BK_SHIFT_UP: begin
            // move elements up, read i-1 then write it at i
            if (i_ff == posc - 1'b1) begin
               wr_en    = 1'b1;
               wr_addr  = IDX_W'(i_ff);
               wr_data  = job_ff.value;
               count_in = count_ff + 1'b1;
            end else if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(i_ff - 1'b1);
               pend_in = 1'b1;
            end else begin
               wr_en   = 1'b1;
               wr_addr = IDX_W'(i_ff);
               wr_data = rd_ff;
               i_in    = i_ff - 1'b1;
            end
         end
         BK_DELRD: begin
            // first read captures the removed word, then shift down
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(i_ff);
               pend_in = 1'b1;
               i_in    = i_ff + 1'b1;
            end else begin
               if (i_ff == posc) oval_in = rd_ff;
               else begin
                  wr_en   = 1'b1;
                  wr_addr = IDX_W'(i_ff - 2'd2);
                  wr_data = rd_ff;
               end
               if (i_ff >= count_ff) count_in = count_ff - 1'b1;
               else begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(i_ff);
                  pend_in = 1'b1;
                  i_in    = i_ff + 1'b1;
               end
            end
         end
         BK_TRAV: begin
            if (!pend_ff) begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(i_ff);
               pend_in = 1'b1;
               i_in    = i_ff + 1'b1;
            end else if (out_free) begin
               ov_in    = 1'b1;
               ost_in   = ST_OK;
               oval_in  = rd_ff;
               olast_in = (i_ff == count_ff);
               if (i_ff < count_ff) begin
                  rd_en   = 1'b1;
                  rd_addr = IDX_W'(i_ff);
                  pend_in = 1'b1;
               end
               i_in = i_ff + 1'b1;
            end else pend_in = 1'b1;
         end
         BK_EMIT: if (out_free) ov_in = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         count_ff  <= '0;
         exists_ff <= 1'b0;
         pend_ff   <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         exists_ff <= exists_in;
         pend_ff   <= pend_in;
         ov_ff     <= ov_in;
      end
      i_ff     <= i_in;
      ost_ff   <= ost_in;
      oval_ff  <= oval_in;
      ofp_ff   <= ofp_in;
      olast_ff <= olast_in;
      if (job_take) job_ff <= job_data;
   end

   // drive the result channel; length is the current count
   assign rsp_valid          = ov_ff;
   assign rsp_status         = ost_ff;
   assign rsp_value_out      = 32'(signed'(oval_ff));
   assign rsp_found_position = ofp_ff;
   assign rsp_list_length    = 7'(count_ff);
   assign rsp_is_initialized = exists_ff;
   assign rsp_last           = olast_ff;

endmodule
